FILE: rtl/snp_pkg.sv
// Shared widths, register indexes and saturating helpers for the screen-space
// nearest point pick core. Used by rtl/screen_nearest_point_pick_core.sv.
// No dependencies.
package snp_pkg;

    localparam int POINT_W = 32;               // Q16.16 world coordinate
    localparam int COEFF_W = 16;               // Q4.12 matrix coefficient
    localparam int LANE_W  = 16;               // coefficient lane pitch in a row word
    localparam int ROW_W   = 64;
    localparam int ACC_W   = 50;               // row sum never exceeds 2^48
    localparam int Q_W     = ACC_W - 12;       // sum after dropping 12 fraction bits
    localparam int OPND_W  = 33;               // shared multiplier operand
    localparam int PROD_W  = 2 * OPND_W;
    localparam int DIV_W   = 56;               // |W * span * 128| < 2^55
    localparam int CNT_W   = 6;
    localparam int IDX_W   = 3;
    localparam int PIX_W   = 16;
    localparam int RAD_W   = 24;
    localparam int SQ_W    = 64;

    typedef logic [IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_CLIP_ROW_X = 3'd0;
    localparam cfg_idx_t REG_CLIP_ROW_Y = 3'd1;
    localparam cfg_idx_t REG_CLIP_ROW_W = 3'd2;
    localparam cfg_idx_t REG_VIEW_ROW_Z = 3'd3;
    localparam cfg_idx_t REG_VIEWPORT   = 3'd4;
    localparam cfg_idx_t REG_CURSOR     = 3'd5;
    localparam cfg_idx_t REG_RADIUS_SQ  = 3'd6;

    localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] S32_NEG_MAX = 32'sh8000_0001;
    localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

    // floor(v / 4096), saturated to signed 32 bits
    function automatic logic signed [31:0] reduce_q16(input logic signed [ACC_W-1:0] v);
        logic signed [Q_W-1:0] q;
        q = v[ACC_W-1:12];
        if (q[Q_W-1:31] != {(Q_W-31){q[Q_W-1]}})
            return q[Q_W-1] ? S32_MIN : S32_MAX;
        return q[31:0];
    endfunction

    // signed quotient from magnitude and sign, saturated to signed 32 bits
    function automatic logic signed [31:0] sat_quotient(input logic [DIV_W-1:0] mag,
                                                        input logic neg);
        if (neg)
        begin
            if ((|mag[DIV_W-1:32]) || (mag[31] && (|mag[30:0])))
                return S32_MIN;
            return -$signed(mag[31:0]);
        end
        if (|mag[DIV_W-1:31])
            return S32_MAX;
        return $signed(mag[31:0]);
    endfunction

    // clamp to +-(2^31-1)
    function automatic logic signed [31:0] clamp_delta(input logic signed [32:0] v);
        if (!v[32] && v[31])
            return S32_MAX;
        if (v[32] && (!v[31] || (v[30:0] == '0)))
            return S32_NEG_MAX;
        return v[31:0];
    endfunction

    // s8 / 256 rounded half away from zero, saturated to 16 bits
    function automatic logic signed [PIX_W-1:0] round_pixel(input logic signed [31:0] s8);
        logic [32:0] mag;
        logic [32:0] sum;
        logic [24:0] r;
        mag = s8[31] ? (33'd0 - {1'b1, s8}) : {1'b0, s8};
        sum = mag + 33'd128;
        r   = sum[32:8];
        if (s8[31])
        begin
            if ((|r[24:16]) || (r[15] && (|r[14:0])))
                return PIX_MIN;
            return -$signed(r[15:0]);
        end
        if (|r[24:15])
            return PIX_MAX;
        return $signed(r[15:0]);
    endfunction

    // (sum of squares) >> 8, saturated to 32 bits unsigned
    function automatic logic [31:0] scale_distance(input logic [SQ_W-1:0] sq);
        if (|sq[SQ_W-1:40])
            return 32'hFFFF_FFFF;
        return sq[39:8];
    endfunction

endpackage

FILE: rtl/screen_nearest_point_pick_core.sv
// Screen-space nearest point pick core, built on snp_pkg.
// A point holds the core from acceptance until it is finished, skipping the screen steps when clip w is zero;
// a last point's result word goes valid as it finishes, later if the previous word is still held.
// Points are taken one at a time, s_tready only in idle; most time goes to the one-bit-per-cycle
// divider run once per screen axis (56 steps each) and 16 passes through the shared 33x33 multiplier.
// Reset (rst_n async, active low) zeroes registers and clears search state, as each result does.
module screen_nearest_point_pick_core
(
    input  logic         clk,
    input  logic         rst_n,
    // point stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // point_x, point_y, point_z
    input  logic         s_tlast,   // last_point
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // pick_x, pick_y, pick_z, screen_x, screen_y
    output logic         m_tuser,   // found
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT_INIT,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_DOT_RED,
        ST_CHECK,
        ST_SCR_PREP,
        ST_SCR_MUL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_FIX,
        ST_DELTA,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // configuration registers
    logic [snp_pkg::ROW_W-1:0] clip_row_x_reg, clip_row_y_reg, clip_row_w_reg, view_row_z_reg;
    logic [31:0]               viewport_reg, cursor_reg;
    logic [snp_pkg::RAD_W-1:0] radius_reg;

    state_t state_reg;
    logic [1:0] row_reg, lane_reg;
    logic       axis_reg, last_reg;
    logic signed [snp_pkg::POINT_W-1:0] pt_reg [3];
    logic signed [snp_pkg::ACC_W-1:0]   acc_reg;
    logic signed [snp_pkg::PROD_W-1:0]  prod_reg;
    logic signed [31:0] cx_reg, cy_reg, cw_reg, vz_reg;
    logic signed [32:0] span_reg;
    logic [snp_pkg::DIV_W-1:0] div_quo_reg;
    logic [31:0]               div_rem_reg, div_dvs_reg;
    logic                      div_neg_reg;
    logic [snp_pkg::CNT_W-1:0] div_cnt_reg;
    logic signed [31:0] s8_reg [2];
    logic signed [31:0] delta_reg [2];
    logic [snp_pkg::SQ_W-1:0] sq_reg;

    // search state
    logic [31:0]        best_dist_reg;
    logic signed [31:0] best_depth_reg;
    logic [31:0]        best_world_reg [3];
    logic signed [snp_pkg::PIX_W-1:0] best_scr_reg [2];
    logic               any_found_reg;

    // result word
    logic         out_valid_reg;
    logic [127:0] out_data_reg;
    logic         out_found_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_row_x_reg <= '0;
            clip_row_y_reg <= '0;
            clip_row_w_reg <= '0;
            view_row_z_reg <= '0;
            viewport_reg   <= '0;
            cursor_reg     <= '0;
            radius_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                snp_pkg::REG_CLIP_ROW_X: clip_row_x_reg <= cfg_data;
                snp_pkg::REG_CLIP_ROW_Y: clip_row_y_reg <= cfg_data;
                snp_pkg::REG_CLIP_ROW_W: clip_row_w_reg <= cfg_data;
                snp_pkg::REG_VIEW_ROW_Z: view_row_z_reg <= cfg_data;
                snp_pkg::REG_VIEWPORT:   viewport_reg   <= cfg_data[31:0];
                snp_pkg::REG_CURSOR:     cursor_reg     <= cfg_data[31:0];
                snp_pkg::REG_RADIUS_SQ:  radius_reg     <= cfg_data[snp_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // coefficient and coordinate selection for the dot products
    logic [snp_pkg::ROW_W-1:0] row_word;
    logic signed [snp_pkg::COEFF_W-1:0] coef;
    logic signed [snp_pkg::POINT_W-1:0] coord;

    always_comb
    begin
        unique case (row_reg)
            2'd0:    row_word = clip_row_x_reg;
            2'd1:    row_word = clip_row_y_reg;
            2'd2:    row_word = clip_row_w_reg;
            default: row_word = view_row_z_reg;
        endcase
        coef = row_word[{lane_reg, 4'b0} +: snp_pkg::COEFF_W];
        unique case (lane_reg)
            2'd0:    coord = pt_reg[0];
            2'd1:    coord = pt_reg[1];
            default: coord = pt_reg[2];
        endcase
    end

    // shared multiplier operands
    logic signed [snp_pkg::OPND_W-1:0] mul_a, mul_b;
    logic [15:0] extent;

    assign extent = axis_reg ? viewport_reg[31:16] : viewport_reg[15:0];

    always_comb
    begin
        unique case (state_reg)
            ST_DOT_MUL:
            begin
                mul_a = snp_pkg::OPND_W'(coef);
                mul_b = snp_pkg::OPND_W'(coord);
            end
            ST_SCR_MUL:
            begin
                mul_a = $signed({17'b0, extent});
                mul_b = span_reg;
            end
            ST_SQ_MUL:
            begin
                mul_a = snp_pkg::OPND_W'(delta_reg[axis_reg]);
                mul_b = snp_pkg::OPND_W'(delta_reg[axis_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one restoring division step
    logic [32:0] rem_shift;
    logic        rem_ge;
    logic [32:0] rem_diff;

    assign rem_shift = {div_rem_reg, div_quo_reg[snp_pkg::DIV_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_dvs_reg});
    assign rem_diff  = rem_shift - {1'b0, div_dvs_reg};

    // numerator magnitude for the divider
    logic signed [snp_pkg::ACC_W-1:0] num;
    logic [snp_pkg::ACC_W-1:0]        num_mag;
    logic [31:0]                      cw_mag;

    assign num     = prod_reg[snp_pkg::ACC_W-1:0];
    assign num_mag = num[snp_pkg::ACC_W-1] ? snp_pkg::ACC_W'(-num) : num;
    assign cw_mag  = cw_reg[31] ? 32'(-cw_reg) : cw_reg;

    logic signed [snp_pkg::ACC_W-1:0] acc_sum;
    logic signed [32:0] delta_raw;
    logic [15:0]        cursor_axis;
    logic [31:0]        dist_px;
    logic [31:0]        radius_px;
    logic               take;
    logic               emit;

    assign acc_sum     = acc_reg + prod_reg[snp_pkg::ACC_W-1:0];
    assign cursor_axis = axis_reg ? cursor_reg[31:16] : cursor_reg[15:0];
    assign delta_raw   = {s8_reg[axis_reg][31], s8_reg[axis_reg]} - $signed({9'b0, cursor_axis, 8'b0});
    assign dist_px     = snp_pkg::scale_distance(sq_reg);
    assign radius_px   = {radius_reg, 8'b0};
    assign take        = (dist_px <= radius_px) &&
                         ((dist_px < best_dist_reg) ||
                          ((dist_px == best_dist_reg) && (vz_reg < best_depth_reg)));
    // a new result word loads when the output register is free or drains this cycle
    assign emit        = (state_reg == ST_FINISH) && last_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_reg        <= '0;
            lane_reg       <= '0;
            axis_reg       <= 1'b0;
            last_reg       <= 1'b0;
            pt_reg         <= '{default: '0};
            acc_reg        <= '0;
            prod_reg       <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            cw_reg         <= '0;
            vz_reg         <= '0;
            span_reg       <= '0;
            div_quo_reg    <= '0;
            div_rem_reg    <= '0;
            div_dvs_reg    <= '0;
            div_neg_reg    <= 1'b0;
            div_cnt_reg    <= '0;
            s8_reg         <= '{default: '0};
            delta_reg      <= '{default: '0};
            sq_reg         <= '0;
            best_dist_reg  <= '1;
            best_depth_reg <= snp_pkg::S32_MAX;
            best_world_reg <= '{default: '0};
            best_scr_reg   <= '{default: '0};
            any_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_found_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !emit)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        pt_reg[0] <= s_tdata[31:0];
                        pt_reg[1] <= s_tdata[63:32];
                        pt_reg[2] <= s_tdata[95:64];
                        last_reg  <= s_tlast;
                        row_reg   <= '0;
                        lane_reg  <= 2'd3;
                        state_reg <= ST_DOT_INIT;
                    end
                end
                ST_DOT_INIT:
                begin
                    // constant term: coefficient * 2^28
                    acc_reg   <= {{(snp_pkg::ACC_W-snp_pkg::COEFF_W-28){coef[snp_pkg::COEFF_W-1]}},
                                  coef, 28'b0};
                    lane_reg  <= '0;
                    state_reg <= ST_DOT_MUL;
                end
                ST_DOT_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_DOT_ACC;
                end
                ST_DOT_ACC:
                begin
                    acc_reg <= acc_sum;
                    if (lane_reg == 2'd2)
                        state_reg <= ST_DOT_RED;
                    else
                    begin
                        lane_reg  <= lane_reg + 2'd1;
                        state_reg <= ST_DOT_MUL;
                    end
                end
                ST_DOT_RED:
                begin
                    unique case (row_reg)
                        2'd0:    cx_reg <= snp_pkg::reduce_q16(acc_reg);
                        2'd1:    cy_reg <= snp_pkg::reduce_q16(acc_reg);
                        2'd2:    cw_reg <= snp_pkg::reduce_q16(acc_reg);
                        default: vz_reg <= snp_pkg::reduce_q16(acc_reg);
                    endcase
                    lane_reg <= 2'd3;
                    if (row_reg == 2'd3)
                        state_reg <= ST_CHECK;
                    else
                    begin
                        row_reg   <= row_reg + 2'd1;
                        state_reg <= ST_DOT_INIT;
                    end
                end
                ST_CHECK:
                begin
                    axis_reg  <= 1'b0;
                    state_reg <= (cw_reg == '0) ? ST_FINISH : ST_SCR_PREP;
                end
                ST_SCR_PREP:
                begin
                    // x: cx + cw, y: cw - cy
                    if (axis_reg)
                        span_reg <= {cw_reg[31], cw_reg} - {cy_reg[31], cy_reg};
                    else
                        span_reg <= {cx_reg[31], cx_reg} + {cw_reg[31], cw_reg};
                    state_reg <= ST_SCR_MUL;
                end
                ST_SCR_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_DIV_LOAD;
                end
                ST_DIV_LOAD:
                begin
                    div_quo_reg <= {num_mag[snp_pkg::DIV_W-8:0], 7'b0};
                    div_rem_reg <= '0;
                    div_dvs_reg <= cw_mag;
                    div_neg_reg <= num[snp_pkg::ACC_W-1] ^ cw_reg[31];
                    div_cnt_reg <= snp_pkg::CNT_W'(snp_pkg::DIV_W - 1);
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_rem_reg <= rem_ge ? rem_diff[31:0] : rem_shift[31:0];
                    div_quo_reg <= {div_quo_reg[snp_pkg::DIV_W-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0)
                        state_reg <= ST_DIV_FIX;
                end
                ST_DIV_FIX:
                begin
                    s8_reg[axis_reg] <= snp_pkg::sat_quotient(div_quo_reg, div_neg_reg);
                    state_reg        <= ST_DELTA;
                end
                ST_DELTA:
                begin
                    delta_reg[axis_reg] <= snp_pkg::clamp_delta(delta_raw);
                    if (axis_reg)
                    begin
                        axis_reg  <= 1'b0;
                        sq_reg    <= '0;
                        state_reg <= ST_SQ_MUL;
                    end
                    else
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= ST_SCR_PREP;
                    end
                end
                ST_SQ_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC:
                begin
                    sq_reg <= sq_reg + prod_reg[snp_pkg::SQ_W-1:0];
                    if (axis_reg)
                        state_reg <= ST_UPDATE;
                    else
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_UPDATE:
                begin
                    if (take)
                    begin
                        best_dist_reg     <= dist_px;
                        best_depth_reg    <= vz_reg;
                        best_world_reg[0] <= pt_reg[0];
                        best_world_reg[1] <= pt_reg[1];
                        best_world_reg[2] <= pt_reg[2];
                        best_scr_reg[0]   <= snp_pkg::round_pixel(s8_reg[0]);
                        best_scr_reg[1]   <= snp_pkg::round_pixel(s8_reg[1]);
                        any_found_reg     <= 1'b1;
                    end
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!last_reg)
                        state_reg <= ST_IDLE;
                    else if (emit)
                    begin
                        // bests hold zero when nothing was found
                        out_valid_reg  <= 1'b1;
                        out_found_reg  <= any_found_reg;
                        out_data_reg   <= {best_scr_reg[1], best_scr_reg[0], best_world_reg[2],
                                           best_world_reg[1], best_world_reg[0]};
                        best_dist_reg  <= '1;
                        best_depth_reg <= snp_pkg::S32_MAX;
                        best_world_reg <= '{default: '0};
                        best_scr_reg   <= '{default: '0};
                        any_found_reg  <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
